// ----- rtl/mwpo_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the multi-waveform phase oscillator.
// Has no dependencies; imported by the oscillator core.
package mwpo_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_BITS    = 16;
    localparam int STEP_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int TOP_BITS       = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM_SELECT = 1'd1;

    // Request operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAWTOOTH = 2'd2,
        WAVE_SQUARE   = 2'd3
    } wave_sel_t;

    // Half pi in Q30, used to build the quarter-wave sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ----- rtl/multi_waveform_phase_oscillator_core.sv -----
`timescale 1ns / 1ps
// Phase-accumulator oscillator core: sine, triangle, sawtooth and square wave
// added with saturation to a Q1.15 sample stream. Depends on mwpo_pkg.
// A sample tick result passes through the stage-one register, then the output register.
// Throughput: one request per cycle unless out_ready stalls the output; the registered read
// of the quarter-wave sine ROM forms the first stage and the saturating add the second.
// Reset clears the phase, both configuration registers and all valid flags.
module multi_waveform_phase_oscillator_core #(
    parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic signed [mwpo_pkg::SAMPLE_BITS-1:0] input_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mwpo_pkg::SAMPLE_BITS-1:0] output_sample
);
    import mwpo_pkg::*;

    localparam int TB      = SINE_TABLE_BITS;
    localparam int QTR_N   = 1 << TB;
    localparam logic [TB:0] QTR_N_IDX = (TB + 1)'(QTR_N);

    typedef logic [15:0] sine_rom_t [0:QTR_N];

    // Quarter-wave table by an integer Taylor series in Q30, evaluated at
    // elaboration only.
    function automatic sine_rom_t build_sine_table();
        sine_rom_t         tbl;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        logic [63:0]       v;
        int                i;
        for (i = 0; i <= QTR_N; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) >> TB;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            if (sum < 0)
            begin
                sum = '0;
            end
            v = (64'(sum) * 64'd32768 + 64'd536870912) >> 30;
            if (v > 64'd32768)
            begin
                v = 64'd32768;
            end
            tbl[i] = v[15:0];
        end
        return tbl;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_table();

    // Configuration registers.
    logic [STEP_BITS-1:0] phase_step_reg;
    wave_sel_t            wave_sel_reg;

    // Phase state.
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_aligned;
    logic [TOP_BITS-1:0]   q;

    // Stage one: ROM data plus everything else needed for the wave.
    logic                          s1_valid_reg;
    logic                          s1_move;
    logic [15:0]                   rom_data_reg;
    logic                          s1_sine_reg;
    logic                          s1_neg_reg;
    logic signed [16:0]            s1_wave_reg;
    logic signed [16:0]            s1_wave_next;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;

    // Stage two: output register.
    logic                          out_valid_reg;
    logic                          out_move;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_next;

    logic [TB-1:0]      k;
    logic [TB:0]        rom_idx;
    logic [16:0]        h15;
    logic [17:0]        tri_fall;
    logic signed [16:0] wave_s2;
    logic signed [17:0] sum_s2;
    logic               accept;

    generate
        if (PHASE_BITS >= TOP_BITS)
        begin : g_wide_phase
            assign q            = phase_reg[PHASE_BITS-1 -: TOP_BITS];
            assign step_aligned = PHASE_BITS'(phase_step_reg) << (PHASE_BITS - TOP_BITS);
        end
        else
        begin : g_narrow_phase
            assign q            = {phase_reg, {(TOP_BITS - PHASE_BITS){1'b0}}};
            assign step_aligned = phase_step_reg[STEP_BITS-1 -: PHASE_BITS];
        end
    endgenerate

    assign out_move = !out_valid_reg || out_ready;
    assign s1_move  = !s1_valid_reg || out_move;
    assign in_ready = s1_move;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (op == OP_RESTART)
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + step_aligned;
            end
        end
    end

    // Sine index folds the second and fourth quadrants back onto the table.
    assign k       = q[29 -: TB];
    assign rom_idx = q[30] ? (QTR_N_IDX - {1'b0, k}) : {1'b0, k};

    assign h15      = q[31:15];
    assign tri_fall = 18'd65536 - {1'b0, h15};

    always_comb
    begin
        case (wave_sel_reg)
            WAVE_TRIANGLE:
            begin
                if (q[31:30] == 2'b00)
                begin
                    s1_wave_next = $signed({1'b0, h15[15:0]});
                end
                else if (q[31:30] == 2'b11)
                begin
                    // Subtracting 2^17 leaves the 17-bit pattern unchanged.
                    s1_wave_next = $signed(h15);
                end
                else
                begin
                    s1_wave_next = $signed(tri_fall[16:0]);
                end
            end
            WAVE_SAWTOOTH:
            begin
                s1_wave_next = 17'(signed'(q[31:16]));
            end
            WAVE_SQUARE:
            begin
                s1_wave_next = q[31] ? -17'sd32768 : 17'sd32768;
            end
            default:
            begin
                s1_wave_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            wave_sel_reg   <= WAVE_SINE;
            phase_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:      phase_step_reg <= cfg_data[STEP_BITS-1:0];
                    REG_WAVEFORM_SELECT: wave_sel_reg   <= wave_sel_t'(cfg_data[1:0]);
                    default:             ;
                endcase
            end
            phase_reg <= phase_next;
            if (s1_move)
            begin
                s1_valid_reg <= accept && (op == OP_TICK);
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Sine ROM read and stage-one payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            rom_data_reg  <= SINE_ROM[rom_idx];
            s1_sine_reg   <= (wave_sel_reg == WAVE_SINE);
            s1_neg_reg    <= q[31];
            s1_wave_reg   <= s1_wave_next;
            s1_sample_reg <= input_sample;
        end
    end

    assign wave_s2 = !s1_sine_reg ? s1_wave_reg :
                     s1_neg_reg   ? -$signed({1'b0, rom_data_reg}) :
                                    $signed({1'b0, rom_data_reg});
    assign sum_s2  = 18'(s1_sample_reg) + 18'(wave_s2);

    always_comb
    begin
        if (sum_s2 > 18'sd32767)
        begin
            out_sample_next = 16'sh7fff;
        end
        else if (sum_s2 < -18'sd32768)
        begin
            out_sample_next = 16'sh8000;
        end
        else
        begin
            out_sample_next = sum_s2[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move && s1_valid_reg)
        begin
            out_sample_reg <= out_sample_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign output_sample = out_sample_reg;

    // A restart request leaves the phase at zero.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_RESTART) |=> phase_reg == '0)
        else $error("phase not cleared after restart");

    // A tick advances the phase by exactly one aligned step.
    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_TICK) |=> phase_reg == $past(phase_reg + step_aligned))
        else $error("phase did not advance by one step");

    // An accepted tick always occupies stage one on the next cycle.
    a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_TICK) |=> s1_valid_reg)
        else $error("accepted tick lost before stage one");

    // A stage-one item is held while the output is stalled.
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_sample_reg))
        else $error("stage one dropped a stalled item");

endmodule
